// File: design/mts_pkg.sv
// Package for the minimum-tracking stack: request and response structs,
// operation codes, controller state codes and shared constants. No dependencies.
`default_nettype none

package mts_pkg;

  localparam int unsigned STACK_DEPTH_DEFAULT = 64;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned COUNT_OUT_W = 7;
  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_POP  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [WORD_W-1:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] top_value;
    logic signed [WORD_W-1:0] min_value;
    logic                     is_empty;
    logic                     overflow;
    logic                     underflow;
    logic [COUNT_OUT_W-1:0]   entry_count;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FETCH = 2'b10
  } state_t;

endpackage : mts_pkg

`default_nettype wire

// File: design/min_tracking_stack.sv
// Minimum-tracking stack top level: stack memory, cached top entry and
// response register. Depends on mts_pkg.
//
// Usage: each request on the cmd channel (cmd_valid/cmd_stall) pushes
// push_value, pops the top entry or only reads. Each request gives exactly
// one response on the rsp channel (rsp_valid/rsp_stall): top value, running
// minimum, empty flag, overflow/underflow flags and the entry count, all
// describing the stack after the operation. An empty stack reads -1.
// Push, read and a pop that empties or underflows the stack are answered
// in ST_IDLE: the response is registered at the edge that accepts it.
// A pop that leaves entries answers from ST_FETCH, which holds off the
// next request, as the new top entry comes from the stack memory, whose
// read port is registered. The top entry is held in registers, so pushes
// and reads never wait on the memory. Sustained rate: one request per
// cycle for pushes, reads and pops that empty or underflow the stack.
// A waiting response does not block the next request as long as the
// receiver takes it in the same cycle; while rsp_stall is high
// with a response waiting, cmd_stall is raised. Reset (rst, synchronous)
// empties the stack and drops any waiting response; memory contents are
// not cleared, since only written entries are ever read.
`default_nettype none

module min_tracking_stack #(
  parameter int unsigned STACK_DEPTH = mts_pkg::STACK_DEPTH_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cmd_valid,
  output logic              cmd_stall,
  input  wire mts_pkg::cmd_t cmd,
  output logic              rsp_valid,
  input  wire logic         rsp_stall,
  output mts_pkg::rsp_t     rsp
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned W  = mts_pkg::WORD_W;
  localparam int unsigned COUNT_OUT_PAD = mts_pkg::COUNT_OUT_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [CW-1:0] TWO_C = CW'(2);

  // Stack memory: value in the upper half, running minimum in the lower.
  logic [2*W-1:0] mem [STACK_DEPTH];
  logic [2*W-1:0] rd_data;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [2*W-1:0] wr_data;

  mts_pkg::state_t state, state_next;
  logic [CW-1:0]   count, count_next;
  logic signed [W-1:0] top_val, top_val_next;
  logic signed [W-1:0] top_min, top_min_next;
  mts_pkg::rsp_t   rsp_next;
  logic            produce;
  logic            accept;
  logic            slot_free;
  logic            over, under;
  logic signed [W-1:0] push_min;
  logic [CW+COUNT_OUT_PAD-1:0] count_wide;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign slot_free = !rsp_valid || !rsp_stall;
  assign cmd_stall = !((state == mts_pkg::ST_IDLE) && slot_free);
  assign accept    = cmd_valid && !cmd_stall;

  // Minimum of the new entry and all entries below it.
  assign push_min = ((count != '0) && (top_min < cmd.push_value)) ? top_min : cmd.push_value;

  always_comb begin
    state_next   = state;
    count_next   = count;
    top_val_next = top_val;
    top_min_next = top_min;
    over         = 1'b0;
    under        = 1'b0;
    produce      = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = AW'(count - TWO_C);
    wr_en        = 1'b0;
    wr_addr      = count[AW-1:0];
    wr_data      = {cmd.push_value, push_min};
    case (state)
      mts_pkg::ST_IDLE: begin
        if (accept) begin
          produce = 1'b1;
          case (cmd.mode)
            mts_pkg::MODE_PUSH: begin
              if (count >= DEPTH_C) begin
                over = 1'b1;
              end else begin
                wr_en        = 1'b1;
                count_next   = count + ONE_C;
                top_val_next = cmd.push_value;
                top_min_next = push_min;
              end
            end
            mts_pkg::MODE_POP: begin
              if (count == '0) begin
                under = 1'b1;
              end else begin
                count_next = count - ONE_C;
                if (count >= TWO_C) begin
                  // The entry below the old top must be fetched first.
                  rd_en      = 1'b1;
                  produce    = 1'b0;
                  state_next = mts_pkg::ST_FETCH;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      mts_pkg::ST_FETCH: begin
        top_val_next = rd_data[2*W-1:W];
        top_min_next = rd_data[W-1:0];
        produce      = 1'b1;
        state_next   = mts_pkg::ST_IDLE;
      end
      default: begin
        state_next = mts_pkg::ST_IDLE;
      end
    endcase
  end

  assign count_wide = {{COUNT_OUT_PAD{1'b0}}, count_next};

  always_comb begin
    rsp_next.is_empty    = (count_next == '0);
    rsp_next.top_value   = rsp_next.is_empty ? mts_pkg::EMPTY_WORD : top_val_next;
    rsp_next.min_value   = rsp_next.is_empty ? mts_pkg::EMPTY_WORD : top_min_next;
    rsp_next.overflow    = over;
    rsp_next.underflow   = under;
    rsp_next.entry_count = count_wide[mts_pkg::COUNT_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mts_pkg::ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (produce) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top_val <= top_val_next;
    top_min <= top_min_next;
    if (produce) begin
      rsp <= rsp_next;
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("stack count exceeds depth");

  a_empty_reads_minus_one : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.is_empty) |->
      (rsp.top_value == mts_pkg::EMPTY_WORD && rsp.min_value == mts_pkg::EMPTY_WORD))
    else $error("empty response does not read -1");

  a_fetch_slot_free : assert property (@(posedge clk) disable iff (rst)
    (state == mts_pkg::ST_FETCH) |-> !rsp_valid)
    else $error("response slot occupied during fetch");

  a_flags_exclusive : assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.overflow && rsp.underflow))
    else $error("overflow and underflow raised together");

  a_push_grows : assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(accept) && $past(cmd.mode) == mts_pkg::MODE_PUSH &&
     $past(count) < DEPTH_C) |-> (count == $past(count) + ONE_C))
    else $error("accepted push did not grow the stack");

endmodule : min_tracking_stack

`default_nettype wire

// File: tb/tb_min_tracking_stack.sv
// Self-checking testbench for min_tracking_stack: drives push, pop and read
// requests, predicts every response with a shadow stack and compares them.
// Depends on mts_pkg and the min_tracking_stack RTL.
`default_nettype none

module tb_min_tracking_stack;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = mts_pkg::STACK_DEPTH_DEFAULT;
  // Mode 3 has no meaning of its own and must behave as a read.
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int unsigned IDLE_PCT = 16;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam logic signed [mts_pkg::WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [mts_pkg::WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           cmd_valid = 1'b0;
  logic           cmd_stall;
  mts_pkg::cmd_t  cmd = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  mts_pkg::rsp_t  rsp;

  // Shadow copy of the stack, advanced once per accepted request.
  logic signed [mts_pkg::WORD_W-1:0] shadow_values [DEPTH];
  logic signed [mts_pkg::WORD_W-1:0] shadow_minima [DEPTH];
  int unsigned                       shadow_count = 0;

  mts_pkg::rsp_t pending_views [$];
  bit            jitter_on = 1'b1;
  int unsigned   fault_count = 0;

  min_tracking_stack i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb_min_tracking_stack NOT OK");
    $finish;
  end

  function automatic mts_pkg::rsp_t step_shadow_stack(
      input logic [1:0] m, input logic signed [mts_pkg::WORD_W-1:0] v);
    mts_pkg::rsp_t                     view;
    logic signed [mts_pkg::WORD_W-1:0] floor_min;
    view = '0;
    if (m == mts_pkg::MODE_PUSH) begin
      if (shadow_count >= DEPTH) begin
        view.overflow = 1'b1;
      end else begin
        floor_min = v;
        if (shadow_count > 0 && shadow_minima[shadow_count-1] < v) begin
          floor_min = shadow_minima[shadow_count-1];
        end
        shadow_values[shadow_count] = v;
        shadow_minima[shadow_count] = floor_min;
        shadow_count++;
      end
    end else if (m == mts_pkg::MODE_POP) begin
      if (shadow_count == 0) begin
        view.underflow = 1'b1;
      end else begin
        shadow_count--;
      end
    end
    if (shadow_count == 0) begin
      view.top_value = mts_pkg::EMPTY_WORD;
      view.min_value = mts_pkg::EMPTY_WORD;
      view.is_empty  = 1'b1;
    end else begin
      view.top_value = shadow_values[shadow_count-1];
      view.min_value = shadow_minima[shadow_count-1];
    end
    view.entry_count = mts_pkg::COUNT_OUT_W'(shadow_count);
    return view;
  endfunction

  // Values lean towards the extremes and a narrow band around zero, so that
  // equal minima and sign boundaries turn up often.
  function automatic logic signed [mts_pkg::WORD_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return mts_pkg::EMPTY_WORD;
      3:       return '0;
      4, 5:    return mts_pkg::WORD_W'(int'($urandom_range(20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick_mode(input int unsigned push_pct,
                                           input int unsigned pop_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < push_pct) return mts_pkg::MODE_PUSH;
    if (roll < push_pct + pop_pct) return mts_pkg::MODE_POP;
    return $urandom_range(1) ? mts_pkg::MODE_READ : MODE_SPARE;
  endfunction

  task automatic send_request(input logic [1:0] m,
                              input logic signed [mts_pkg::WORD_W-1:0] v);
    while (jitter_on && $urandom_range(99) < IDLE_PCT) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= '{mode: m, push_value: v};
    do @(posedge clk); while (cmd_stall);
    pending_views.push_back(step_shadow_stack(m, v));
  endtask

  task automatic park_until_drained();
    cmd_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  task automatic note_fault(input string what, input mts_pkg::rsp_t want,
                            input mts_pkg::rsp_t got);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) begin
      $display("%0t: %s: expected top %0d min %0d empty %0b ovf %0b unf %0b count %0d",
               $realtime, what, want.top_value, want.min_value, want.is_empty,
               want.overflow, want.underflow, want.entry_count);
      $display("%0t: %s: actual   top %0d min %0d empty %0b ovf %0b unf %0b count %0d",
               $realtime, what, got.top_value, got.min_value, got.is_empty,
               got.overflow, got.underflow, got.entry_count);
    end
  endtask

  always @(posedge clk) begin
    mts_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_views.size() == 0) begin
        note_fault("unexpected response", '0, rsp);
      end else begin
        want = pending_views.pop_front();
        if (rsp.top_value !== want.top_value || rsp.min_value !== want.min_value ||
            rsp.is_empty !== want.is_empty || rsp.overflow !== want.overflow ||
            rsp.underflow !== want.underflow || rsp.entry_count !== want.entry_count) begin
          note_fault("response mismatch", want, rsp);
        end
      end
    end
    rsp_stall <= jitter_on && ($urandom_range(99) < IDLE_PCT);
  end

  task automatic test_empty_stack();
    send_request(mts_pkg::MODE_READ, WORD_MAX);
    send_request(mts_pkg::MODE_POP, WORD_MIN);
    send_request(MODE_SPARE, mts_pkg::EMPTY_WORD);
    send_request(mts_pkg::MODE_POP, '0);
  endtask

  task automatic test_extremes();
    send_request(mts_pkg::MODE_PUSH, WORD_MAX);
    send_request(mts_pkg::MODE_PUSH, WORD_MIN);
    send_request(mts_pkg::MODE_PUSH, WORD_MAX);
    send_request(mts_pkg::MODE_READ, '0);
    send_request(mts_pkg::MODE_POP, '0);
    send_request(mts_pkg::MODE_POP, '0);
    send_request(mts_pkg::MODE_PUSH, '0);
    send_request(mts_pkg::MODE_PUSH, mts_pkg::EMPTY_WORD);
    send_request(mts_pkg::MODE_PUSH, mts_pkg::EMPTY_WORD);
    send_request(MODE_SPARE, WORD_MIN);
    send_request(mts_pkg::MODE_POP, WORD_MAX);
    send_request(mts_pkg::MODE_POP, '0);
    send_request(mts_pkg::MODE_POP, '0);
    send_request(mts_pkg::MODE_POP, '0);
    send_request(mts_pkg::MODE_POP, '0);
  endtask

  // Fill to the brim, push into a full stack, read it, then empty it and pop once more.
  task automatic test_full_stack();
    while (shadow_count < DEPTH) send_request(mts_pkg::MODE_PUSH, pick_value());
    repeat (3) send_request(mts_pkg::MODE_PUSH, pick_value());
    send_request(MODE_SPARE, $urandom);
    while (shadow_count > 0) send_request(mts_pkg::MODE_POP, $urandom);
    send_request(mts_pkg::MODE_POP, $urandom);
  endtask

  // Segments alternate between filling, draining and balanced traffic so that
  // the stack depth rises and falls over the run.
  task automatic test_random_walk(input int unsigned n_items);
    int unsigned push_pct;
    int unsigned pop_pct;
    for (int unsigned i = 0; i < n_items; i++) begin
      case ((i / 50) % 3)
        0:       begin push_pct = 70; pop_pct = 20; end
        1:       begin push_pct = 20; pop_pct = 70; end
        default: begin push_pct = 40; pop_pct = 40; end
      endcase
      send_request(pick_mode(push_pct, pop_pct), pick_value());
    end
  endtask

  task automatic test_back_to_back(input int unsigned n_items);
    jitter_on = 1'b0;
    for (int unsigned i = 0; i < n_items; i++) begin
      send_request(pick_mode(45, 45), pick_value());
    end
    jitter_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_empty_stack();
    test_extremes();
    park_until_drained();
    test_full_stack();
    park_until_drained();
    test_random_walk(650);
    test_back_to_back(200);
    park_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_views.size() != 0) begin
      fault_count += pending_views.size();
    end
    if (fault_count == 0) begin
      $display("tb_min_tracking_stack OK");
    end else begin
      $display("tb_min_tracking_stack NOT OK");
    end
    $finish;
  end

endmodule : tb_min_tracking_stack

`default_nettype wire
